// ===== hw/rtl/vidad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vidad_pkg
// Shared types and constants of the varint id array decoder.
// ----------------------------------------------------------------------------
package vidad_pkg;

	localparam int unsigned SLOT_BITS = 16;
	localparam int unsigned ID_W      = 32;
	localparam int unsigned USED_W    = 16;

	localparam logic [32:0] SLOT_LIMIT = 33'(1) << SLOT_BITS;

	localparam logic [7:0] MARKER_BYTE = 8'h40;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EOF      = 2'd1,
		ST_RANGE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_ID        = 2'd0,
		REG_RELATIVE_MODE = 2'd1,
		REG_MARKER_VALUE  = 2'd2,
		REG_CAPACITY      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [ID_W-1:0]   id_value;
		logic [USED_W-1:0] slot_index;
		logic              last;
		status_t           status;
	} result_t;

	function automatic logic buffer_full(input logic [USED_W-1:0] used,
	                                     input logic [USED_W-1:0] cap);
		buffer_full = (used >= cap) || (33'(used) >= SLOT_LIMIT);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vidad_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vidad_ifs
// Valid/ready channels of the varint id array decoder.
// ----------------------------------------------------------------------------
interface vidad_in_if
	import vidad_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface vidad_out_if
	import vidad_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   id_value;
	logic [USED_W-1:0] slot_index;
	logic              last;
	status_t           status;

	modport source (output valid, output id_value, output slot_index, output last,
		output status, input ready);
	modport sink (input valid, input id_value, input slot_index, input last,
		input status, output ready);
endinterface

interface vidad_cfg_if
	import vidad_pkg::*;
();
	logic            valid;
	logic            ready;
	reg_index_t      index;
	logic [ID_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/varint_id_array_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_id_array_decoder
// Decodes a byte stream of varint / delta coded id arrays into stored ids.
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  in       sink       in_byte, end_of_input
//  out      source     id_value, slot_index, last, status
//  cfg      sink       index, data (always ready)
//
//  one byte per cycle; a closing byte that ends the array after a nonzero id
//  also emits the trailing zero, so it yields two results. bytes pass the
//  input register and a four-entry result queue; the input register advances
//  while the queue holds two results or fewer, otherwise it holds its byte
//  and in.ready drops. reset clears the decoder and queue, resets registers.
// ----------------------------------------------------------------------------
module varint_id_array_decoder
	import vidad_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	vidad_in_if.sink    in,
	vidad_out_if.source out,
	vidad_cfg_if.sink   cfg
);

	logic [ID_W-1:0]   max_id_q;
	logic              relative_q;
	logic [ID_W-1:0]   marker_q;
	logic [USED_W-1:0] capacity_q;

	logic [ID_W-1:0]   acc_q;
	logic [ID_W-1:0]   prev_q;
	logic [USED_W-1:0] used_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	result_t    queue_q [4];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] count_q;

	logic advance;
	logic pop;

	result_t           r0;
	result_t           r1;
	logic [1:0]        n_res;
	logic [ID_W-1:0]   acc_d;
	logic [ID_W-1:0]   prev_d;
	logic [USED_W-1:0] used_d;

	assign advance   = valid_s1 && (count_q <= 3'd2);
	assign in.ready  = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign pop       = out.valid && out.ready;

	assign out.valid      = (count_q != 3'd0);
	assign out.id_value   = queue_q[head_q].id_value;
	assign out.slot_index = queue_q[head_q].slot_index;
	assign out.last       = queue_q[head_q].last;
	assign out.status     = queue_q[head_q].status;

	always_comb begin
		logic [ID_W-1:0]   x;
		logic [USED_W-1:0] used_inc;
		x        = {acc_q[ID_W-7:0], byte_s1[5:0]};
		used_inc = used_q + USED_W'(1);
		r0       = '{id_value: '0, slot_index: used_q, last: 1'b1, status: ST_OK};
		r1       = '{id_value: '0, slot_index: used_inc, last: 1'b1, status: ST_OK};
		n_res    = 2'd0;
		acc_d    = acc_q;
		prev_d   = prev_q;
		used_d   = used_q;
		if (eoi_s1) begin
			r0.status = ST_EOF;
			n_res     = 2'd1;
			acc_d     = '0;
			prev_d    = '0;
		end else if (byte_s1[7]) begin
			acc_d = {acc_q[ID_W-8:0], byte_s1[6:0]};
		end else if (relative_q && (x == '0) && (byte_s1 == MARKER_BYTE)) begin
			n_res       = 2'd1;
			r0.id_value = marker_q;
			acc_d       = '0;
			prev_d      = '0;
			if (buffer_full(used_q, capacity_q)) begin
				r0.status = ST_OVERFLOW;
			end else begin
				r0.last = 1'b0;
				used_d  = used_inc;
			end
		end else begin
			if (relative_q) begin
				x = x - ID_W'(1) + prev_q;
			end
			n_res       = 2'd1;
			r0.id_value = x;
			acc_d       = '0;
			prev_d      = '0;
			if ((max_id_q != '0) && (x >= max_id_q)) begin
				r0.status = ST_RANGE;
			end else if (buffer_full(used_q, capacity_q)) begin
				r0.status = ST_OVERFLOW;
			end else begin
				used_d = used_inc;
				if (byte_s1[6]) begin
					r0.last = 1'b0;
					prev_d  = relative_q ? x : prev_q;
				end else if (x != '0) begin
					r0.last = 1'b0;
					n_res   = 2'd2;
					if (buffer_full(used_inc, capacity_q)) begin
						r1.status = ST_OVERFLOW;
					end else begin
						used_d = used_inc + USED_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_id_q   <= '0;
			relative_q <= 1'b0;
			marker_q   <= '0;
			capacity_q <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_ID:        max_id_q   <= cfg.data;
				REG_RELATIVE_MODE: relative_q <= cfg.data[0];
				REG_MARKER_VALUE:  marker_q   <= cfg.data;
				REG_CAPACITY:      capacity_q <= cfg.data[USED_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.valid && in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			byte_s1 <= in.in_byte;
			eoi_s1  <= in.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			prev_q <= '0;
			used_q <= '0;
		end else if (advance) begin
			acc_q  <= acc_d;
			prev_q <= prev_d;
			used_q <= used_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (advance && (n_res != 2'd0)) begin
			queue_q[tail_q] <= r0;
		end
		if (advance && (n_res == 2'd2)) begin
			queue_q[tail_q + 2'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			if (advance) begin
				tail_q <= tail_q + n_res;
			end
			count_q <= count_q + (advance ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the varint id array decoder. Directed and random
// byte streams go in on the input channel. Each output beat is compared
// against a predicted id queue, built from an in-bench decoder of the same
// stream and register settings. Both channels idle and stall in bursts.
// ----------------------------------------------------------------------------
module testbench;
	import vidad_pkg::*;

	logic clk;
	logic arst_n;

	vidad_in_if  in_if();
	vidad_out_if out_if();
	vidad_cfg_if cfg_if();

	varint_id_array_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_if),
		.out    (out_if),
		.cfg    (cfg_if)
	);

	// decoder state and register copies
	logic [31:0] cfg_max_id   = '0;
	logic        cfg_relative = 1'b0;
	logic [31:0] cfg_marker   = '0;
	logic [15:0] cfg_capacity = 16'hFFFF;
	logic [31:0] acc          = '0;
	logic [31:0] prev_id      = '0;
	logic [15:0] slots_used   = '0;

	result_t pending_ids[$];

	int errors       = 0;
	int bytes_sent   = 0;
	int ids_checked  = 0;
	int status_seen[4];
	int in_idle_pct  = 0;
	int out_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("timeout at %0t, %0d results still pending", $time, pending_ids.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sink side stalls
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_if.ready <= 1'b1;
		end
	end

	function automatic bit slots_full();
		return (slots_used >= cfg_capacity) || (33'(slots_used) >= SLOT_LIMIT);
	endfunction

	function automatic void push_id(logic [31:0] v, logic lst, status_t st);
		result_t r;
		r.id_value   = v;
		r.slot_index = slots_used;
		r.last       = lst;
		r.status     = st;
		pending_ids.push_back(r);
	endfunction

	function automatic void restart_array();
		acc     = '0;
		prev_id = '0;
	endfunction

	function automatic bit store_id(logic [31:0] v, logic lst);
		if (slots_full()) begin
			push_id(v, 1'b1, ST_OVERFLOW);
			restart_array();
			return 1'b0;
		end
		push_id(v, lst, ST_OK);
		slots_used = slots_used + 16'd1;
		return 1'b1;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic eoi);
		logic [31:0] x;
		if (eoi) begin
			push_id('0, 1'b1, ST_EOF);
			restart_array();
			return;
		end
		if (b[7]) begin
			acc = {acc[24:0], b[6:0]};
			return;
		end
		x = {acc[25:0], b[5:0]};
		if (cfg_relative) begin
			if (x == 0 && b == MARKER_BYTE) begin
				if (store_id(cfg_marker, 1'b0)) restart_array();
				return;
			end
			x = x - 32'd1 + prev_id;
			prev_id = x;
		end
		if (cfg_max_id != 0 && x >= cfg_max_id) begin
			push_id(x, 1'b1, ST_RANGE);
			restart_array();
			return;
		end
		if (b[6]) begin
			if (store_id(x, 1'b0)) acc = '0;
			return;
		end
		if (x == 0) begin
			if (store_id('0, 1'b1)) restart_array();
			return;
		end
		if (!store_id(x, 1'b0)) return;
		if (store_id('0, 1'b1)) restart_array();
	endfunction

	function automatic void apply_config(reg_index_t idx, logic [31:0] d);
		case (idx)
			REG_MAX_ID:        cfg_max_id   = d;
			REG_RELATIVE_MODE: cfg_relative = d[0];
			REG_MARKER_VALUE:  cfg_marker   = d;
			REG_CAPACITY:      cfg_capacity = d[15:0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result();
		result_t want;
		if (pending_ids.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual id %h slot %0d last %0b status %0d",
				$time, out_if.id_value, out_if.slot_index, out_if.last, out_if.status);
			errors++;
			return;
		end
		want = pending_ids.pop_front();
		ids_checked++;
		status_seen[int'(want.status)]++;
		check_field("id_value", want.id_value, out_if.id_value);
		check_field("slot_index", 32'(want.slot_index), 32'(out_if.slot_index));
		check_field("last", 32'(want.last), 32'(out_if.last));
		check_field("status", 32'(want.status), 32'(out_if.status));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_if.valid && out_if.ready) check_result();
			if (cfg_if.valid && cfg_if.ready) apply_config(cfg_if.index, cfg_if.data);
			if (in_if.valid && in_if.ready) decode_byte(in_if.in_byte, in_if.end_of_input);
		end
	end

	task automatic send_item(logic [7:0] b, logic eoi);
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_if.valid        <= 1'b1;
		in_if.in_byte      <= b;
		in_if.end_of_input <= eoi;
		do @(posedge clk); while (!in_if.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_id(logic [31:0] v, bit more);
		logic [31:0] hi;
		logic [7:0]  grp[$];
		hi = v >> 6;
		while (hi != 0) begin
			grp.push_front({1'b1, hi[6:0]});
			hi = hi >> 7;
		end
		foreach (grp[i]) send_item(grp[i], 1'b0);
		send_item({1'b0, more, v[5:0]}, 1'b0);
	endtask

	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (pending_ids.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
	endtask

	task automatic configure(logic [31:0] lim, bit rel, logic [31:0] mark, logic [15:0] cap);
		wait_idle();
		write_reg(REG_MAX_ID, lim);
		write_reg(REG_RELATIVE_MODE, {31'($urandom), rel});
		write_reg(REG_MARKER_VALUE, mark);
		write_reg(REG_CAPACITY, {16'($urandom), cap});
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_id();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 63);
			1: return $urandom_range(64, 8191);
			2: return $urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] near_capacity(int extra);
		int c;
		c = int'(slots_used) + extra;
		return (c > 65535) ? 16'hFFFF : 16'(c);
	endfunction

	task automatic test_absolute_ids();
		send_item(8'h00, 1'b0);
		send_id(32'd63, 1'b0);
		send_id(32'hFFFF_FFFF, 1'b1);
		send_id(32'd0, 1'b1);
		send_id(32'd1, 1'b0);
		send_item(8'h85, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_range_limit();
		configure(32'd100, 1'b0, '0, 16'hFFFF);
		send_id(32'd99, 1'b0);
		send_id(32'd100, 1'b0);
		configure(32'hFFFF_FFFF, 1'b0, '0, 16'hFFFF);
		send_id(32'hFFFF_FFFE, 1'b0);
		send_id(32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_relative_deltas();
		configure('0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(MARKER_BYTE, 1'b0);
		send_id(32'd10, 1'b1);
		send_id(32'd1, 1'b1);
		send_item(MARKER_BYTE, 1'b0);
		send_item(8'h81, 1'b0);
		send_item(8'h40, 1'b0);
		send_item(8'h00, 1'b0);
		configure('0, 1'b1, '0, 16'hFFFF);
		send_item(MARKER_BYTE, 1'b0);
		send_id(32'd1, 1'b0);
	endtask

	task automatic test_buffer_overflow();
		configure('0, 1'b0, '0, near_capacity(0));
		send_id(32'd5, 1'b0);
		send_item(8'h00, 1'b0);
		configure('0, 1'b0, '0, near_capacity(1));
		send_id(32'd7, 1'b0);
		configure('0, 1'b1, 32'd123, near_capacity(0));
		send_item(MARKER_BYTE, 1'b0);
		configure('0, 1'b0, '0, 16'd0);
		send_item(8'h00, 1'b0);
		configure('0, 1'b0, '0, 16'hFFFF);
	endtask

	task automatic send_array();
		int pick;
		int n_ids;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			send_item(8'($urandom), 1'b0);
		end else if (pick < 9) begin
			send_item(8'($urandom), 1'b1);
		end else if (pick < 13) begin
			repeat ($urandom_range(1, 3)) send_item({1'b1, 7'($urandom)}, 1'b0);
			send_item(8'($urandom), 1'b1);
		end else begin
			n_ids = $urandom_range(1, 6);
			for (int k = 0; k < n_ids; k++) begin
				if (cfg_relative && $urandom_range(0, 9) == 0) begin
					send_item(MARKER_BYTE, 1'b0);
				end else begin
					if ($urandom_range(0, 19) == 0) send_item(8'h80, 1'b0);
					send_id(random_id(), k != n_ids - 1);
				end
			end
		end
	endtask

	task automatic test_random_stream();
		int target;
		int phase_end;
		int pick;
		logic [31:0] lim;
		logic [31:0] mark;
		logic [15:0] cap;
		target = bytes_sent + 1000;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 9);
			lim = (pick < 4) ? 32'd0 : (pick < 6) ? 32'($urandom_range(1, 64)) :
				(pick < 8) ? 32'($urandom_range(1, 1 << 20)) : (pick < 9) ? $urandom :
				32'hFFFF_FFFF;
			pick = $urandom_range(0, 2);
			mark = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			pick = $urandom_range(0, 9);
			cap = (pick < 7) ? 16'hFFFF : (pick < 9) ? near_capacity($urandom_range(0, 30)) :
				16'd0;
			configure(lim, 1'($urandom), mark, cap);
			if (target - bytes_sent < 200) begin
				in_idle_pct   = 0;
				out_stall_pct = 0;
			end else begin
				in_idle_pct   = 10 * $urandom_range(0, 3);
				out_stall_pct = 10 * $urandom_range(0, 3);
			end
			phase_end = bytes_sent + $urandom_range(60, 140);
			while (bytes_sent < phase_end) send_array();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		in_if.valid        = 1'b0;
		in_if.in_byte      = '0;
		in_if.end_of_input = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_MAX_ID;
		cfg_if.data        = '0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		in_idle_pct   = 20;
		out_stall_pct = 20;
		test_absolute_ids();
		test_range_limit();
		test_relative_deltas();
		test_buffer_overflow();
		test_random_stream();

		wait_idle();
		if (pending_ids.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_ids.size());
			errors++;
		end
		$display("sent %0d bytes over absolute, relative, range and overflow settings",
			bytes_sent);
		$display("checked %0d results: ok %0d, end of stream %0d, range %0d, overflow %0d",
			ids_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
